// ----- design/mrot_pkg.sv -----
// Shared types, constants and mark update rule for the meter read outcome tracker.
package mrot_pkg;

    // Two-bit meter mark.
    typedef logic [1:0] mark_t;

    // Mark codes.
    localparam mark_t MARK_OK          = 2'd0;
    localparam mark_t MARK_FAIL_TO_OK  = 2'd1;
    localparam mark_t MARK_OK_TO_FAIL  = 2'd2;
    localparam mark_t MARK_FAIL        = 2'd3;

    // Counted ports and the width of a port counter.
    localparam int NUM_PORTS = 4;
    localparam int CNT_W     = 16;
    localparam int PORT_W    = 3;
    localparam int PSEL_W    = 2;

    // Configuration register map.
    localparam int          CFG_ADDR_W         = 3;
    localparam int          CFG_DATA_W         = 32;
    localparam logic [2:0]  REG_EVENT_REC_ADDR = 3'd0;

    // Stream payload widths.
    localparam int S_TDATA_W = 24;
    localparam int M_TDATA_W = 40;

    // Mark after one outcome, given the previous mark.
    function automatic mark_t next_mark(mark_t old_mark, logic failed, logic tracking);
        mark_t result;
        if (!tracking) begin
            result = failed ? MARK_OK_TO_FAIL : MARK_FAIL_TO_OK;
        end else if (!failed) begin
            result = old_mark[1] ? MARK_FAIL_TO_OK : MARK_OK;
        end else begin
            result = old_mark[1] ? MARK_FAIL : MARK_OK_TO_FAIL;
        end
        return result;
    endfunction

endpackage

// ----- design/mrot_mark_store.sv -----
// Mark memory with a registered read, write-to-read bypass and a clearing pass after reset.
module mrot_mark_store #(
    parameter  int MAX_METERS = 4096,
    localparam int AW         = (MAX_METERS > 1) ? $clog2(MAX_METERS) : 1
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic [AW-1:0]        rd_addr,
    input  logic                 wr_en,
    input  logic [AW-1:0]        wr_addr,
    input  mrot_pkg::mark_t      wr_data,
    output mrot_pkg::mark_t      rd_mark,
    output logic                 busy
);
    import mrot_pkg::*;

    localparam logic [AW-1:0] LAST_ADDR = AW'(MAX_METERS - 1);

    mark_t          mem [MAX_METERS];
    mark_t          rd_data_reg;
    logic           byp_valid_reg;
    mark_t          byp_data_reg;
    logic           clr_active_reg;
    logic [AW-1:0]  clr_addr_reg;
    logic           mem_we;
    logic [AW-1:0]  mem_waddr;
    mark_t          mem_wdata;

    // The clearing pass owns the write port until every entry is zero.
    always_comb begin
        if (clr_active_reg) begin
            mem_we    = 1'b1;
            mem_waddr = clr_addr_reg;
            mem_wdata = MARK_OK;
        end else begin
            mem_we    = wr_en;
            mem_waddr = wr_addr;
            mem_wdata = wr_data;
        end
    end

    // Memory array: one write and one registered read per cycle.
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg  <= mem[rd_addr];
        byp_data_reg <= mem_wdata;
    end

    // A write to the entry being read in the same cycle wins over the stale read.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            byp_valid_reg <= 1'b0;
        end else begin
            byp_valid_reg <= mem_we && (mem_waddr == rd_addr);
        end
    end

    // Clearing pass sweeps one entry per cycle after reset.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_active_reg <= 1'b1;
            clr_addr_reg   <= '0;
        end else if (clr_active_reg) begin
            if (clr_addr_reg == LAST_ADDR) begin
                clr_active_reg <= 1'b0;
            end
            clr_addr_reg <= clr_addr_reg + 1'b1;
        end
    end

    assign rd_mark = byp_valid_reg ? byp_data_reg : rd_data_reg;
    assign busy    = clr_active_reg;

endmodule

// ----- design/meter_read_outcome_tracker.sv -----
// Top level of the meter read outcome tracker: item pipeline, port counters and register port.
//
//  Channel   Direction  Handshake          Payload
//  s_*       in         s_tvalid/s_tready  meter_number, port_index, read_failed
//  m_*       out        m_tvalid/m_tready  accepted (tuser), new_mark, counts (tdata)
//  APB       in         psel/penable       event_recording_on at byte address 0
//
// An item is read from the mark memory in the cycle it is accepted and completes when the
// output register is free, so one item per cycle is sustained while m_tready stays high;
// the memory read and write-back set that figure, with a bypass for back-to-back items on
// the same meter. After reset a clearing pass zeroes the mark memory; s_tready stays low
// during it. A stalled result holds the item in flight and blocks new items.
module meter_read_outcome_tracker #(
    parameter int MAX_METERS = 4096
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    // meter_number [15:0], port_index [18:16], read_failed [19], zero [23:20]
    input  logic [mrot_pkg::S_TDATA_W-1:0]      s_tdata,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // new_mark [1:0], success_count [17:2], failure_count [33:18], zero [39:34]
    output logic [mrot_pkg::M_TDATA_W-1:0]      m_tdata,
    // accepted [0]
    output logic                                m_tuser,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [mrot_pkg::CFG_ADDR_W-1:0]     paddr,
    input  logic [mrot_pkg::CFG_DATA_W-1:0]     pwdata,
    output logic [mrot_pkg::CFG_DATA_W-1:0]     prdata,
    output logic                                pready
);
    import mrot_pkg::*;

    localparam int AW = (MAX_METERS > 1) ? $clog2(MAX_METERS) : 1;
    localparam logic [16:0] MAX_METER_NUM = 17'(MAX_METERS);

    logic [15:0]        s_meter;
    logic [PORT_W-1:0]  s_port;
    logic               s_failed;
    logic               s_in_range;
    logic [AW-1:0]      s_slot;
    logic               s_accept;

    logic               s1_valid_reg;
    logic [AW-1:0]      s1_slot_reg;
    logic               s1_in_range_reg;
    logic [PORT_W-1:0]  s1_port_reg;
    logic               s1_failed_reg;

    logic               out_free;
    logic               s1_done;
    logic [AW-1:0]      rd_addr;
    mark_t              rd_mark;
    logic               mem_busy;
    mark_t              new_mark;
    logic               wr_en;

    logic [CNT_W-1:0]   succ_cnt_reg [NUM_PORTS];
    logic [CNT_W-1:0]   fail_cnt_reg [NUM_PORTS];
    logic [PSEL_W-1:0]  cnt_idx;
    logic               counted;
    logic [CNT_W-1:0]   succ_new;
    logic [CNT_W-1:0]   fail_new;

    logic               m_tvalid_reg;
    logic               m_tvalid_next;
    logic               m_accepted_reg;
    mark_t              m_mark_reg;
    logic [CNT_W-1:0]   m_succ_reg;
    logic [CNT_W-1:0]   m_fail_reg;

    logic               evt_rec_reg;
    logic               cfg_write;

    // Input item unpacking and range check.
    assign s_meter    = s_tdata[15:0];
    assign s_port     = s_tdata[18:16];
    assign s_failed   = s_tdata[19];
    assign s_in_range = (s_meter != 16'd0) && ({1'b0, s_meter} <= MAX_METER_NUM);
    assign s_slot     = AW'(s_meter - 16'd1);

    // Flow control: the item in flight completes when the output register frees up.
    assign out_free = !m_tvalid_reg || m_tready;
    assign s1_done  = s1_valid_reg && out_free;
    assign s_tready = !mem_busy && (!s1_valid_reg || out_free);
    assign s_accept = s_tvalid && s_tready;

    // A stalled item keeps re-reading its own entry.
    assign rd_addr = s_accept ? s_slot : s1_slot_reg;

    mrot_mark_store #(
        .MAX_METERS (MAX_METERS)
    ) u_mark_store (
        .aclk    (aclk),
        .aresetn (aresetn),
        .rd_addr (rd_addr),
        .wr_en   (wr_en),
        .wr_addr (s1_slot_reg),
        .wr_data (new_mark),
        .rd_mark (rd_mark),
        .busy    (mem_busy)
    );

    // Item in flight between memory read and write-back.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (s_accept) begin
            s1_valid_reg <= 1'b1;
        end else if (s1_done) begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            s1_slot_reg     <= s_slot;
            s1_in_range_reg <= s_in_range;
            s1_port_reg     <= s_port;
            s1_failed_reg   <= s_failed;
        end
    end

    // Mark update and port counter increment.
    assign new_mark = next_mark(rd_mark, s1_failed_reg, evt_rec_reg);
    assign wr_en    = s1_done && s1_in_range_reg;
    assign cnt_idx  = s1_port_reg[PSEL_W-1:0];
    assign counted  = (s1_port_reg < PORT_W'(NUM_PORTS));
    assign succ_new = succ_cnt_reg[cnt_idx]
                      + CNT_W'(s1_in_range_reg && !s1_failed_reg);
    assign fail_new = fail_cnt_reg[cnt_idx]
                      + CNT_W'(s1_in_range_reg && s1_failed_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_PORTS; i++) begin
                succ_cnt_reg[i] <= '0;
                fail_cnt_reg[i] <= '0;
            end
        end else if (wr_en && counted) begin
            succ_cnt_reg[cnt_idx] <= succ_new;
            fail_cnt_reg[cnt_idx] <= fail_new;
        end
    end

    // Output register holds one finished item until it is taken.
    always_comb begin
        if (s1_done) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end else begin
            m_tvalid_next = m_tvalid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_done) begin
            m_accepted_reg <= s1_in_range_reg;
            m_mark_reg     <= s1_in_range_reg ? new_mark : MARK_OK;
            m_succ_reg     <= counted ? succ_new : '0;
            m_fail_reg     <= counted ? fail_new : '0;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = m_accepted_reg;
    assign m_tdata  = {6'd0, m_fail_reg, m_succ_reg, m_mark_reg};

    // Configuration register port.
    assign cfg_write = psel && penable && pwrite && pready;
    assign pready    = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            evt_rec_reg <= 1'b0;
        end else if (cfg_write && (paddr == REG_EVENT_REC_ADDR)) begin
            evt_rec_reg <= pwdata[0];
        end
    end

    assign prdata = (paddr == REG_EVENT_REC_ADDR) ? CFG_DATA_W'(evt_rec_reg) : '0;

endmodule
